### rtl/core/lru_directory_cache_macros.svh
// Assertion macros for the lru_directory_cache checker.
// Plain text macros only, no dependencies.
`ifndef LRU_DIRECTORY_CACHE_MACROS_SVH
`define LRU_DIRECTORY_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LRUDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LRUDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/core/lrudc_pkg.sv
// Shared types and constants for the LRU directory cache.
// No dependencies; imported by lrudc_engine, lru_directory_cache and the testbench.
package lrudc_pkg;

  localparam int STAMP_BITS      = 32;
  localparam int OUT_HANDLE_BITS = 32;
  localparam int IN_KEY_BITS     = 64;
  localparam int IN_HANDLE_BITS  = 32;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [IN_KEY_BITS-1:0]    key;
    logic [IN_HANDLE_BITS-1:0] handle;
  } item_t;

  typedef struct packed {
    logic                       hit;
    logic [OUT_HANDLE_BITS-1:0] found_handle;
    logic                       evicted;
    logic [OUT_HANDLE_BITS-1:0] evicted_handle;
  } result_t;

endpackage

### rtl/core/lrudc_req_if.sv
// Request channel of the LRU directory cache: valid/ready plus one request word.
// Depends on nothing; field widths match lrudc_pkg.
interface lrudc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] key;
  logic [31:0] handle;

  modport source (output valid, output operation, output key, output handle, input ready);
  modport sink   (input valid, input operation, input key, input handle, output ready);
endinterface

### rtl/core/lrudc_rsp_if.sv
// Response channel of the LRU directory cache: valid/ready plus one result word.
// Depends on nothing; field widths match lrudc_pkg.
interface lrudc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] found_handle;
  logic        evicted;
  logic [31:0] evicted_handle;

  modport source (output valid, output hit, output found_handle, output evicted,
                  output evicted_handle, input ready);
  modport sink   (input valid, input hit, input found_handle, input evicted,
                  input evicted_handle, output ready);
endinterface

### rtl/core/lrudc_store.sv
// Entry memory: one write port, one read port, registered read data.
// Generic; no package dependency.
module lrudc_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lrudc_engine.sv
// Sequencer of the LRU directory cache: scans the entry memory one entry per
// cycle for a key match or the oldest stamp; writes back on a hit or insert. Uses lrudc_pkg.
module lrudc_engine
  import lrudc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 64,
  parameter int KEY_BITS      = 64,
  parameter int HANDLE_BITS   = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    idle,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
  localparam int WORD_W = KEY_BITS + HANDLE_BITS + STAMP_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state, state_next;
  logic [CNT_W-1:0]       fill, fill_next;
  logic [STAMP_BITS-1:0]  access_clock, access_clock_next;
  logic                   op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [CNT_W-1:0]       rd_cnt, rd_cnt_next;
  logic                   dv, dv_next;
  logic [IDX_W-1:0]       d_idx, d_idx_next;
  logic                   d_last, d_last_next;
  logic [STAMP_BITS-1:0]  best_stamp, best_stamp_next;
  logic [IDX_W-1:0]       best_idx, best_idx_next;
  logic [HANDLE_BITS-1:0] best_handle, best_handle_next;
  result_t                res_next;

  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_waddr;
  logic [WORD_W-1:0]      mem_wdata, mem_rdata;

  logic [CNT_W-1:0]       limit;
  logic                   issue;
  logic [KEY_BITS-1:0]    rd_key, in_key;
  logic [HANDLE_BITS-1:0] rd_handle, in_handle;
  logic [STAMP_BITS-1:0]  rd_stamp, stamp_inc;
  logic                   take;
  logic [STAMP_BITS-1:0]  cur_stamp;
  logic [IDX_W-1:0]       cur_idx;
  logic [HANDLE_BITS-1:0] cur_handle;

  lrudc_store #(
    .DEPTH (CACHE_ENTRIES),
    .WIDTH (WORD_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  assign in_key    = KEY_BITS'(item.key);
  assign in_handle = HANDLE_BITS'(item.handle);

  assign rd_key    = mem_rdata[WORD_W-1 -: KEY_BITS];
  assign rd_handle = mem_rdata[STAMP_BITS +: HANDLE_BITS];
  assign rd_stamp  = mem_rdata[STAMP_BITS-1:0];

  assign stamp_inc = (access_clock == STAMP_MAX) ? access_clock : access_clock + 1'b1;

  assign limit = (op_q == OP_LOOKUP) ? fill : CNT_W'(CACHE_ENTRIES);
  assign issue = (state == S_SCAN) && (rd_cnt < limit);
  assign mem_re = issue;

  // Running minimum: strict less-than keeps the lowest index on ties.
  assign take       = (d_idx == '0) || (rd_stamp < best_stamp);
  assign cur_stamp  = take ? rd_stamp  : best_stamp;
  assign cur_idx    = take ? d_idx     : best_idx;
  assign cur_handle = take ? rd_handle : best_handle;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next        = state;
    fill_next         = fill;
    access_clock_next = access_clock;
    rd_cnt_next       = rd_cnt;
    dv_next           = issue;
    d_idx_next        = rd_cnt[IDX_W-1:0];
    d_last_next       = (rd_cnt + 1'b1 == limit);
    best_stamp_next   = best_stamp;
    best_idx_next     = best_idx;
    best_handle_next  = best_handle;
    res_next          = res;
    mem_we            = 1'b0;
    mem_waddr         = '0;
    mem_wdata         = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_next = '0;
          if (item.operation == OP_LOOKUP && fill == '0) begin
            state_next = S_DONE;
          end else if (item.operation == OP_INSERT && fill < CNT_W'(CACHE_ENTRIES)) begin
            mem_we            = 1'b1;
            mem_waddr         = fill[IDX_W-1:0];
            mem_wdata         = {in_key, in_handle, access_clock};
            access_clock_next = stamp_inc;
            fill_next         = fill + 1'b1;
            state_next        = S_DONE;
          end else begin
            rd_cnt_next = '0;
            state_next  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_cnt_next = rd_cnt + 1'b1;
        end
        if (dv) begin
          if (op_q == OP_LOOKUP) begin
            if (rd_key == key_q) begin
              mem_we                = 1'b1;
              mem_waddr             = d_idx;
              mem_wdata             = {rd_key, rd_handle, access_clock};
              access_clock_next     = stamp_inc;
              res_next.hit          = 1'b1;
              res_next.found_handle = OUT_HANDLE_BITS'(rd_handle);
              state_next            = S_DONE;
            end else if (d_last) begin
              state_next = S_DONE;
            end
          end else begin
            best_stamp_next  = cur_stamp;
            best_idx_next    = cur_idx;
            best_handle_next = cur_handle;
            if (d_last) begin
              mem_we                  = 1'b1;
              mem_waddr               = cur_idx;
              mem_wdata               = {key_q, handle_q, access_clock};
              access_clock_next       = stamp_inc;
              res_next.evicted        = 1'b1;
              res_next.evicted_handle = OUT_HANDLE_BITS'(cur_handle);
              state_next              = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      access_clock <= '0;
      dv           <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      access_clock <= access_clock_next;
      dv           <= dv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      op_q     <= item.operation;
      key_q    <= in_key;
      handle_q <= in_handle;
    end
    rd_cnt      <= rd_cnt_next;
    d_idx       <= d_idx_next;
    d_last      <= d_last_next;
    best_stamp  <= best_stamp_next;
    best_idx    <= best_idx_next;
    best_handle <= best_handle_next;
    res         <= res_next;
  end

endmodule

### rtl/core/lru_directory_cache.sv
// Fully associative key-to-handle cache with least-recently-used replacement.
// Inserts into a non-full cache and lookups on an empty one skip the scan; other lookups
//   read up to the N filled entries, and an insert into a full cache reads all CACHE_ENTRIES.
// One request at a time: a new word is taken only once the sequencer has passed its last
//   result to the output register; a scan reads one entry per cycle over the single read port.
// Reset: fill count, stamp counter and handshake state clear; entry memory is not cleared.
module lru_directory_cache
  import lrudc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 64,
  parameter int KEY_BITS      = 64,
  parameter int HANDLE_BITS   = 32
) (
  input logic         clk,
  input logic         rst,
  lrudc_req_if.sink   req,
  lrudc_rsp_if.source rsp
);

  item_t   item;
  result_t eng_res;
  result_t out_res;
  logic    eng_idle;
  logic    eng_valid;
  logic    eng_ready;
  logic    out_valid;

  // One request word at a time: take it only while the sequencer is idle.
  assign item      = '{operation: req.operation, key: req.key, handle: req.handle};
  assign req.ready = eng_idle;

  lrudc_engine #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && eng_idle),
    .item      (item),
    .idle      (eng_idle),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res)
  );

  // Output register: hold the result word until the sink takes it, so the
  // sequencer can already accept and work on the next request.
  assign eng_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_valid && eng_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_ready) begin
      out_res <= eng_res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.hit            = out_res.hit;
  assign rsp.found_handle   = out_res.found_handle;
  assign rsp.evicted        = out_res.evicted;
  assign rsp.evicted_handle = out_res.evicted_handle;

endmodule

### rtl/core/lrudc_checker.sv
// Port-level checks for lru_directory_cache, attached by bind.
// Depends on lru_directory_cache_macros.svh.
`include "lru_directory_cache_macros.svh"

module lrudc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_hit,
  input logic [31:0] rsp_found_handle,
  input logic        rsp_evicted,
  input logic [31:0] rsp_evicted_handle
);

  logic [65:0] rsp_word;
  logic        unused_zero;

  assign rsp_word    = {rsp_hit, rsp_found_handle, rsp_evicted, rsp_evicted_handle};
  assign unused_zero = (rsp_hit || rsp_found_handle == '0) &&
                       (rsp_evicted || rsp_evicted_handle == '0);

  // A stalled result word holds.
  `LRUDC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

  // One request in flight: ready drops right after a word is taken.
  `LRUDC_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // A result is a hit or an eviction, never both.
  `LRUDC_ASSERT_NOW(a_hit_xor_evict, clk, rst, rsp_valid, !(rsp_hit && rsp_evicted))

  // Handles that do not apply read as zero.
  `LRUDC_ASSERT_NOW(a_zero_fields, clk, rst, rsp_valid, unused_zero)

endmodule

bind lru_directory_cache lrudc_checker u_lrudc_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_hit            (rsp.hit),
  .rsp_found_handle   (rsp.found_handle),
  .rsp_evicted        (rsp.evicted),
  .rsp_evicted_handle (rsp.evicted_handle)
);

### tb/sv/tb_lru_directory_cache.sv
// Self-checking testbench for lru_directory_cache: lookups and inserts against a
// cycle-free LRU predictor. Depends on lru_directory_cache, lrudc_pkg, lrudc_req_if and lrudc_rsp_if.
`timescale 1ns / 1ps

module tb_lru_directory_cache;
  import lrudc_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int KEY_POOL     = 100;  // more keys than slots, so hits and misses mix
  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT  = 4000; // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 80;   // drain after the last result, to cover a scan over all ENTRIES

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrudc_req_if req_ch ();
  lrudc_rsp_if rsp_ch ();

  lru_directory_cache #(
    .CACHE_ENTRIES(ENTRIES),
    .KEY_BITS     (64),
    .HANDLE_BITS  (32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Words waiting to be driven, and results predicted for accepted words.
  item_t   pending_words [$];
  result_t predicted_results [$];

  int          total_words = 0;
  int          words_taken = 0;
  int unsigned fault_cnt   = 0;
  int unsigned stall_cycles = 0;

  // No idling on either side while this window of words goes through.
  wire steady = (words_taken >= 400) && (words_taken < 700);

  // Shadow copy of the cache contents.
  logic [IN_KEY_BITS-1:0]     key_mem    [0:ENTRIES-1];
  logic [IN_HANDLE_BITS-1:0]  handle_mem [0:ENTRIES-1];
  logic [STAMP_BITS-1:0]      stamp_mem  [0:ENTRIES-1];
  int                         fill_cnt  = 0;
  logic [STAMP_BITS-1:0]      stamp_ctr = '0;

  logic [63:0] hot_keys [0:KEY_POOL-1];

  // Apply one word to the shadow cache and return the result it must produce.
  function automatic result_t cache_access(item_t w);
    result_t r;
    int      slot;
    int      i;
    r    = '0;
    slot = -1;
    if (w.operation == OP_LOOKUP) begin
      // Take the lowest-index match among the filled slots.
      for (i = 0; i < fill_cnt; i++) begin
        if (slot < 0 && key_mem[i] == w.key) slot = i;
      end
      if (slot >= 0) begin
        r.hit          = 1'b1;
        r.found_handle = handle_mem[slot];
      end
    end else begin
      if (fill_cnt < ENTRIES) begin
        slot     = fill_cnt;
        fill_cnt = fill_cnt + 1;
      end else begin
        // Smallest stamp goes; strict compare keeps the lowest index on a tie.
        slot = 0;
        for (i = 1; i < ENTRIES; i++) begin
          if (stamp_mem[i] < stamp_mem[slot]) slot = i;
        end
        r.evicted        = 1'b1;
        r.evicted_handle = handle_mem[slot];
      end
      key_mem[slot]    = w.key;
      handle_mem[slot] = w.handle;
    end
    // Hits and inserts take a stamp; the counter saturates. Misses leave it alone.
    if (slot >= 0) begin
      stamp_mem[slot] = stamp_ctr;
      if (stamp_ctr != STAMP_MAX) stamp_ctr = stamp_ctr + 1'b1;
    end
    return r;
  endfunction

  task automatic queue_word(logic op, logic [63:0] key, logic [31:0] handle);
    item_t w;
    w.operation = op;
    w.key       = key;
    w.handle    = handle;
    pending_words.push_back(w);
  endtask

  // Driver: hold the word until it is taken, then advance or idle.
  item_t next_word;
  item_t taken_word;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_LOOKUP;
      req_ch.key       <= '0;
      req_ch.handle    <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_word.operation = req_ch.operation;
        taken_word.key       = req_ch.key;
        taken_word.handle    = req_ch.handle;
        predicted_results.push_back(cache_access(taken_word));
        words_taken <= words_taken + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
          next_word        = pending_words.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= next_word.operation;
          req_ch.key       <= next_word.key;
          req_ch.handle    <= next_word.handle;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, stall at random.
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error({"result with nothing predicted: hit %0d found_handle %h ",
                  "evicted %0d evicted_handle %h"},
                 rsp_ch.hit, rsp_ch.found_handle, rsp_ch.evicted, rsp_ch.evicted_handle);
          fault_cnt++;
        end else begin
          want = predicted_results.pop_front();
          if (rsp_ch.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, rsp_ch.hit);
            fault_cnt++;
          end
          if (rsp_ch.found_handle !== want.found_handle) begin
            $error("found_handle: expected %h, actual %h",
                   want.found_handle, rsp_ch.found_handle);
            fault_cnt++;
          end
          if (rsp_ch.evicted !== want.evicted) begin
            $error("evicted: expected %0d, actual %0d", want.evicted, rsp_ch.evicted);
            fault_cnt++;
          end
          if (rsp_ch.evicted_handle !== want.evicted_handle) begin
            $error("evicted_handle: expected %h, actual %h",
                   want.evicted_handle, rsp_ch.evicted_handle);
            fault_cnt++;
          end
        end
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 7);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[lru_directory_cache] ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  logic [63:0] pick;
  int          roll;
  int          n;

  initial begin
    // Directed part. Lookups on the empty cache must miss.
    queue_word(OP_LOOKUP, 64'h0, 32'h0);
    queue_word(OP_LOOKUP, '1, '1);
    // Extreme keys and handles, then alternating bit patterns.
    queue_word(OP_INSERT, 64'h0, 32'hFFFF_FFFF);
    queue_word(OP_INSERT, '1, 32'h0);
    queue_word(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    queue_word(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    queue_word(OP_LOOKUP, 64'h0, 32'h0);
    queue_word(OP_LOOKUP, '1, 32'h0);
    // Near misses: one bit off a stored key at each end.
    queue_word(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
    queue_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0);
    // Duplicate insert: lookup must still return the lower slot.
    queue_word(OP_INSERT, 64'h0, 32'h1234_5678);
    queue_word(OP_LOOKUP, 64'h0, 32'h0);
    // Handle field on a lookup must be ignored.
    queue_word(OP_LOOKUP, 64'h5555_5555_5555_5555, 32'hDEAD_BEEF);
    queue_word(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
    queue_word(OP_LOOKUP, 64'h0000_0000_0000_0001, 32'h0);

    // Random part: keys mostly from a pool so that hits, duplicates and
    // evictions are common once the cache fills.
    for (n = 0; n < KEY_POOL; n++) hot_keys[n] = {$urandom, $urandom};
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = hot_keys[$urandom_range(KEY_POOL-1)];
      roll = $urandom_range(99);
      if (roll < 40) begin
        queue_word(OP_INSERT, pick, $urandom);
      end else if (roll < 75) begin
        queue_word(OP_LOOKUP, pick, $urandom);
      end else if (roll < 85) begin
        pick[$urandom_range(63)] ^= 1'b1;
        queue_word(OP_LOOKUP, pick, $urandom);
      end else if (roll < 92) begin
        queue_word(OP_LOOKUP, {$urandom, $urandom}, $urandom);
      end else begin
        queue_word(OP_INSERT, {$urandom, $urandom}, $urandom);
      end
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, where every clocked update has settled.
    while (words_taken != total_words) @(negedge clk);
    while (predicted_results.size() != 0) @(negedge clk);
    // Leave room for a stray result after the last one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("[lru_directory_cache] OK");
    end else begin
      $display("[lru_directory_cache] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/lrudc_pkg.sv
rtl/core/lrudc_req_if.sv
rtl/core/lrudc_rsp_if.sv
rtl/core/lrudc_store.sv
rtl/core/lrudc_engine.sv
rtl/core/lru_directory_cache.sv
rtl/core/lrudc_checker.sv
tb/sv/tb_lru_directory_cache.sv
